FILE: rtl/core/bsws_pkg.sv
package bsws_pkg;

  // geometry of the store
  localparam int WORD_BITS = 32;
  localparam int WORDS     = 32;
  localparam int CAP       = WORDS * WORD_BITS;

  // fixed field widths
  localparam int OP_W  = 3;
  localparam int IDX_W = 11;
  localparam int CNT_W = 11;
  localparam int ST_W  = 2;

  // internal position width, wide enough for the end position
  localparam int POS_W = ($clog2(CAP + 1) > IDX_W) ? $clog2(CAP + 1) : IDX_W;
  localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int OFF_W = $clog2(WORD_BITS);

  // position / WORD_BITS as a multiply by a rounded-up reciprocal
  localparam int     DIV_SH  = POS_W + OFF_W;
  localparam longint DIV_M   = ((longint'(1) << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int     DIV_M_W = POS_W + 1;

  localparam logic [POS_W-1:0] CAP_P     = POS_W'(CAP);
  localparam logic [WA_W-1:0]  LAST_WORD = WA_W'(WORDS - 1);

  // operation codes
  localparam logic [OP_W-1:0] OP_SET        = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd1;
  localparam logic [OP_W-1:0] OP_TEST       = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR_ALL  = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND_FIRST = 3'd4;
  localparam logic [OP_W-1:0] OP_FIND_NEXT  = 3'd5;
  localparam logic [OP_W-1:0] OP_FIND_PREV  = 3'd6;

  // status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [ST_W-1:0] ST_SEARCH = 2'd2;

  // how a request is carried out
  typedef enum logic [1:0] {
    K_RMW,
    K_UP,
    K_DOWN,
    K_IMM
  } kind_e;

  typedef struct packed {
    logic capture;
    logic split;
    logic rd_start;
    logic rd_step;
    logic rmw_done;
    logic scan_done;
    logic imm_done;
  } bsws_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  scan_end;
    logic  out_free;
  } bsws_sts_t;

  function automatic logic [OFF_W-1:0] low_index(logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] iso;
    logic [OFF_W-1:0]     r;
    iso = w & (~w + WORD_BITS'(1));
    r   = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (iso[i]) begin
        r = r | OFF_W'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [OFF_W-1:0] high_index(logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] rev;
    for (int i = 0; i < WORD_BITS; i++) begin
      rev[i] = w[WORD_BITS-1-i];
    end
    return OFF_W'(WORD_BITS - 1) - low_index(rev);
  endfunction

endpackage

FILE: rtl/core/bsws_req_if.sv
interface bsws_req_if;
  logic                      valid;
  logic                      ready;
  logic [bsws_pkg::OP_W-1:0]  operation;
  logic [bsws_pkg::IDX_W-1:0] bit_index;

  modport source (output valid, output operation, output bit_index, input ready);
  modport sink   (input valid, input operation, input bit_index, output ready);
endinterface

FILE: rtl/core/bsws_rsp_if.sv
interface bsws_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      bit_value;
  logic [bsws_pkg::IDX_W-1:0] found_position;
  logic [bsws_pkg::CNT_W-1:0] set_count;
  logic [bsws_pkg::ST_W-1:0]  status;

  modport source (output valid, output bit_value, output found_position, output set_count,
                  output status, input ready);
  modport sink   (input valid, input bit_value, input found_position, input set_count,
                  input status, output ready);
endinterface

FILE: rtl/core/bsws_ctrl.sv
module bsws_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  bsws_pkg::bsws_sts_t sts_i,
  output bsws_pkg::bsws_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPLIT,
    S_ADDR,
    S_MODIFY,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = (state_q == S_IDLE) && req_valid_i;
    cmd_o.split     = (state_q == S_SPLIT);
    cmd_o.rd_start  = (state_q == S_ADDR);
    cmd_o.rmw_done  = (state_q == S_MODIFY) && sts_i.out_free;
    cmd_o.scan_done = (state_q == S_SCAN) && sts_i.scan_end && sts_i.out_free;
    cmd_o.rd_step   = (state_q == S_SCAN) && !sts_i.scan_end;
    cmd_o.imm_done  = (state_q == S_FINISH) && sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_SPLIT;
      end
      S_SPLIT: begin
        state_d = (sts_i.kind == bsws_pkg::K_IMM) ? S_FINISH : S_ADDR;
      end
      S_ADDR: begin
        state_d = (sts_i.kind == bsws_pkg::K_RMW) ? S_MODIFY : S_SCAN;
      end
      S_MODIFY: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      S_SCAN: begin
        if (sts_i.scan_end && sts_i.out_free) state_d = S_IDLE;
      end
      S_FINISH: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q == S_SPLIT))
    else $error("accepted request did not move to split");

  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.rd_start, cmd_o.rd_step, cmd_o.rmw_done, cmd_o.scan_done,
              cmd_o.imm_done}))
    else $error("more than one datapath action in a cycle");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rmw_done || cmd_o.scan_done || cmd_o.imm_done) |=> req_ready_o)
    else $error("not ready after a result was produced");
`endif

endmodule

FILE: rtl/core/bsws_dpath.sv
module bsws_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bsws_pkg::bsws_cmd_t        cmd_i,
  output bsws_pkg::bsws_sts_t        sts_o,
  input  logic [bsws_pkg::OP_W-1:0]  req_operation_i,
  input  logic [bsws_pkg::IDX_W-1:0] req_bit_index_i,
  input  logic                       rsp_ready_i,
  output logic                       rsp_valid_o,
  output logic                       rsp_bit_value_o,
  output logic [bsws_pkg::IDX_W-1:0] rsp_found_position_o,
  output logic [bsws_pkg::CNT_W-1:0] rsp_set_count_o,
  output logic [bsws_pkg::ST_W-1:0]  rsp_status_o
);

  localparam int WB    = bsws_pkg::WORD_BITS;
  localparam int POS_W = bsws_pkg::POS_W;
  localparam int WA_W  = bsws_pkg::WA_W;
  localparam int OFF_W = bsws_pkg::OFF_W;
  localparam int PRD_W = POS_W + bsws_pkg::DIV_M_W;
  localparam logic [WB-1:0] ONES = '1;

  // request registers
  logic [bsws_pkg::OP_W-1:0]  op_q;
  logic [bsws_pkg::IDX_W-1:0] idx_q;
  logic [POS_W-1:0]           pos_q, pos_d;

  // addressing
  logic [PRD_W-1:0]  prod;
  logic [WA_W-1:0]   word_idx_q;
  logic [POS_W-1:0]  off_full;
  logic [OFF_W-1:0]  off_q;
  logic [WA_W-1:0]   scan_addr_q;
  logic [WA_W-1:0]   rd_addr_q;
  logic [WA_W-1:0]   rd_sel;
  logic              first_q;
  logic              down;

  // store
  logic [WB-1:0]     mem_q [bsws_pkg::WORDS];
  logic [bsws_pkg::WORDS-1:0] vld_q;
  logic [WB-1:0]     rd_data_q;
  logic              rd_vld_q;
  logic [bsws_pkg::CNT_W-1:0] cnt_q, cnt_d;

  // evaluation
  logic [WB-1:0]     word_v, mask, masked, onehot, new_word;
  logic              hit, at_last, cur_bit, wr_en;
  logic [OFF_W-1:0]  bit_pos;
  logic [POS_W-1:0]  found_scan;
  logic [bsws_pkg::ST_W-1:0] scan_status;

  // decode
  logic [POS_W-1:0]  idx_w;
  bsws_pkg::kind_e   kind;
  logic [bsws_pkg::IDX_W-1:0] imm_found;
  logic [bsws_pkg::ST_W-1:0]  imm_status;
  logic              out_free, load;

  // output register
  logic                       out_vld_q;
  logic                       out_value_q;
  logic [bsws_pkg::IDX_W-1:0] out_found_q;
  logic [bsws_pkg::CNT_W-1:0] out_count_q;
  logic [bsws_pkg::ST_W-1:0]  out_status_q;

  always_comb begin
    case (req_operation_i)
      bsws_pkg::OP_FIND_FIRST: pos_d = '0;
      bsws_pkg::OP_FIND_NEXT:  pos_d = POS_W'(req_bit_index_i) + POS_W'(1);
      bsws_pkg::OP_FIND_PREV:  pos_d = POS_W'(req_bit_index_i) - POS_W'(1);
      default:                 pos_d = POS_W'(req_bit_index_i);
    endcase
  end

  always_comb begin
    idx_w      = POS_W'(idx_q);
    kind       = bsws_pkg::K_IMM;
    imm_found  = '0;
    imm_status = bsws_pkg::ST_OK;
    case (op_q)
      bsws_pkg::OP_SET, bsws_pkg::OP_CLEAR, bsws_pkg::OP_TEST: begin
        if (idx_w >= bsws_pkg::CAP_P) imm_status = bsws_pkg::ST_RANGE;
        else kind = bsws_pkg::K_RMW;
      end
      bsws_pkg::OP_FIND_FIRST: kind = bsws_pkg::K_UP;
      bsws_pkg::OP_FIND_NEXT: begin
        imm_found = bsws_pkg::CAP_P[bsws_pkg::IDX_W-1:0];
        if (idx_w > bsws_pkg::CAP_P) imm_status = bsws_pkg::ST_RANGE;
        else if (idx_w == bsws_pkg::CAP_P) imm_status = bsws_pkg::ST_SEARCH;
        else if (pos_q != bsws_pkg::CAP_P) kind = bsws_pkg::K_UP;
      end
      bsws_pkg::OP_FIND_PREV: begin
        imm_found = bsws_pkg::CAP_P[bsws_pkg::IDX_W-1:0];
        if (idx_w > bsws_pkg::CAP_P) imm_status = bsws_pkg::ST_RANGE;
        else if (idx_w == '0) imm_status = bsws_pkg::ST_SEARCH;
        else kind = bsws_pkg::K_DOWN;
      end
      default: kind = bsws_pkg::K_IMM;
    endcase
  end

  assign down     = (op_q == bsws_pkg::OP_FIND_PREV);
  assign prod     = PRD_W'(pos_q) * PRD_W'(bsws_pkg::DIV_M);
  assign off_full = pos_q - POS_W'(word_idx_q) * POS_W'(WB);
  assign rd_sel   = cmd_i.rd_start ? word_idx_q : scan_addr_q;

  function automatic logic [WA_W-1:0] step_addr(logic [WA_W-1:0] a, logic dn);
    logic [WA_W-1:0] r;
    r = a;
    if (dn) begin
      if (a != '0) r = a - WA_W'(1);
    end else begin
      if (a != bsws_pkg::LAST_WORD) r = a + WA_W'(1);
    end
    return r;
  endfunction

  // word under evaluation and its search
  always_comb begin
    word_v  = rd_vld_q ? rd_data_q : '0;
    if (!first_q)  mask = ONES;
    else if (down) mask = ONES >> (OFF_W'(WB - 1) - off_q);
    else           mask = ONES << off_q;
    masked  = word_v & mask;
    hit     = |masked;
    bit_pos = down ? bsws_pkg::high_index(masked) : bsws_pkg::low_index(masked);
    at_last = down ? (rd_addr_q == '0) : (rd_addr_q == bsws_pkg::LAST_WORD);
    if (hit) begin
      found_scan  = POS_W'(rd_addr_q) * POS_W'(WB) + POS_W'(bit_pos);
      scan_status = bsws_pkg::ST_OK;
    end else begin
      found_scan  = bsws_pkg::CAP_P;
      scan_status = down ? bsws_pkg::ST_SEARCH : bsws_pkg::ST_OK;
    end
  end

  // read-modify-write of one bit
  always_comb begin
    onehot  = WB'(1) << off_q;
    cur_bit = word_v[off_q];
    wr_en   = 1'b0;
    new_word = word_v;
    cnt_d   = cnt_q;
    if (op_q == bsws_pkg::OP_SET && !cur_bit) begin
      wr_en    = 1'b1;
      new_word = word_v | onehot;
      cnt_d    = cnt_q + bsws_pkg::CNT_W'(1);
    end else if (op_q == bsws_pkg::OP_CLEAR && cur_bit) begin
      wr_en    = 1'b1;
      new_word = word_v & ~onehot;
      cnt_d    = cnt_q - bsws_pkg::CNT_W'(1);
    end
  end

  assign out_free = !out_vld_q || rsp_ready_i;
  assign load     = cmd_i.rmw_done || cmd_i.scan_done || cmd_i.imm_done;

  always_comb begin
    sts_o          = '0;
    sts_o.kind     = kind;
    sts_o.scan_end = hit || at_last;
    sts_o.out_free = out_free;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= req_operation_i;
      idx_q <= req_bit_index_i;
      pos_q <= pos_d;
    end
    if (cmd_i.split) begin
      word_idx_q <= prod[bsws_pkg::DIV_SH +: WA_W];
    end
    if (cmd_i.rd_start) begin
      off_q <= off_full[OFF_W-1:0];
    end
    if (cmd_i.rd_start || cmd_i.rd_step) begin
      rd_data_q   <= mem_q[rd_sel];
      rd_addr_q   <= rd_sel;
      first_q     <= cmd_i.rd_start;
      scan_addr_q <= step_addr(rd_sel, down);
    end
    if (cmd_i.rmw_done && wr_en) begin
      mem_q[word_idx_q] <= new_word;
    end
    if (cmd_i.rmw_done) begin
      out_value_q  <= cur_bit;
      out_found_q  <= '0;
      out_count_q  <= cnt_d;
      out_status_q <= bsws_pkg::ST_OK;
    end else if (cmd_i.scan_done) begin
      out_value_q  <= 1'b0;
      out_found_q  <= found_scan[bsws_pkg::IDX_W-1:0];
      out_count_q  <= cnt_q;
      out_status_q <= scan_status;
    end else if (cmd_i.imm_done) begin
      out_value_q  <= 1'b0;
      out_found_q  <= imm_found;
      out_count_q  <= (op_q == bsws_pkg::OP_CLEAR_ALL) ? '0 : cnt_q;
      out_status_q <= imm_status;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.rd_start || cmd_i.rd_step) begin
        rd_vld_q <= vld_q[rd_sel];
      end
      if (cmd_i.rmw_done) begin
        cnt_q <= cnt_d;
        if (wr_en) vld_q[word_idx_q] <= 1'b1;
      end else if (cmd_i.imm_done && op_q == bsws_pkg::OP_CLEAR_ALL) begin
        cnt_q <= '0;
        vld_q <= '0;
      end
      if (load) out_vld_q <= 1'b1;
      else if (rsp_ready_i) out_vld_q <= 1'b0;
    end
  end

  assign rsp_valid_o          = out_vld_q;
  assign rsp_bit_value_o      = out_value_q;
  assign rsp_found_position_o = out_found_q;
  assign rsp_set_count_o      = out_count_q;
  assign rsp_status_o         = out_status_q;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !rsp_ready_i) |-> !load)
    else $error("result register loaded while still holding a result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bsws_pkg::CAP >= (1 << bsws_pkg::CNT_W)) || (32'(cnt_q) <= bsws_pkg::CAP))
    else $error("set count above capacity");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan_done && hit) |-> (found_scan < bsws_pkg::CAP_P))
    else $error("search hit beyond the store");
`endif

endmodule

FILE: rtl/core/bitmap_set_with_scan.sv
// bitmap of WORDS x WORD_BITS bits with a running count of set bits
// request channel req_i: operation and bit_index, one transfer per request
//   (set, clear, test, clear all, find first, find next, find previous)
// response channel rsp_o: exactly one transfer per request, in request order,
//   carrying bit_value, found_position, set_count and status
// steps from request transfer to response valid:
//   requests settled without touching the store (range errors,
//   clear all, end-of-map searches, unknown operations): split, then finish
//   set, clear and test: split, address, then one read-modify-write of a word
//   searches: split, address, then a scan of words until a hit or the end of the map
// throughput: one request at a time; a search
//   is bound by the word-per-cycle scan through the single-port store
// reset clears the count and the per-word valid bits, so the whole map reads
//   as zero at once; clear all does the same
// the response sits in an output register; a new request is taken while it
//   waits, and a stalled receiver only holds the next result at its last step
module bitmap_set_with_scan (
  input logic         clk_i,
  input logic         rst_ni,
  bsws_req_if.sink    req_i,
  bsws_rsp_if.source  rsp_o
);

  bsws_pkg::bsws_cmd_t cmd;
  bsws_pkg::bsws_sts_t sts;
  logic                ready;

  // request handshake: ready only while the sequencer is idle
  assign req_i.ready = ready;

  // sequencer: split index, then address word and modify or scan, or go straight to finish
  bsws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // store, count, word scan and output register
  bsws_dpath u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .req_operation_i      (req_i.operation),
    .req_bit_index_i      (req_i.bit_index),
    .rsp_ready_i          (rsp_o.ready),
    .rsp_valid_o          (rsp_o.valid),
    .rsp_bit_value_o      (rsp_o.bit_value),
    .rsp_found_position_o (rsp_o.found_position),
    .rsp_set_count_o      (rsp_o.set_count),
    .rsp_status_o         (rsp_o.status)
  );

endmodule
